/* rtl/tilm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tilm_pkg: shared types and constants of the thread idle load monitor
// Beat layouts, sequencer states, divider hand-off and fixed arithmetic
// constants.
// ----------------------------------------------------------------------------
package tilm_pkg;

  localparam int unsigned IDLE_INPUTS = 6;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned PCT_W       = 7;
  localparam int unsigned DVD_W       = 34;
  localparam int unsigned DIVR_W      = 48;
  localparam int unsigned BUSYK_W     = 23;
  localparam int unsigned MPROD_W     = 23;

  // floor(x / 1000) = (x * KILO_RECIP) >> KILO_SHIFT for any 32-bit x
  localparam logic [31:0] KILO_RECIP    = 32'd2199023256;
  localparam int unsigned KILO_SHIFT    = 41;
  localparam logic [11:0] PCT_SCALE     = 12'd3276;
  localparam logic [PCT_W-1:0] HUNDRED  = 7'd100;
  // floor(x / 100) = (x * HUNDRED_RECIP) >> 30 for x below 2^23
  localparam logic [23:0] HUNDRED_RECIP = 24'd10737419;
  localparam int unsigned HUNDRED_SHIFT = 30;

  typedef enum logic {
    REQ_START  = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_type_e;

  typedef struct packed {
    logic        req_type;
    logic [31:0] core_cycles;
    logic [31:0] idle_cycles_t0;
    logic [31:0] idle_cycles_t1;
    logic [31:0] idle_cycles_t2;
    logic [31:0] idle_cycles_t3;
    logic [31:0] idle_cycles_t4;
    logic [31:0] idle_cycles_t5;
    logic [31:0] tick_end;
    logic [31:0] tick_restart;
    logic [15:0] cpu_mips;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] thread_index;
    logic [PCT_W-1:0] idle_percent;
    logic [15:0]      busy_mips;
    logic             last_result;
  } res_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             over;
    logic [PCT_W-1:0] quot;
  } div_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MULT,
    ST_RD,
    ST_DIFF,
    ST_SCALE,
    ST_DIVS,
    ST_DIVW,
    ST_PCT,
    ST_MIPS,
    ST_OUT,
    ST_BASE
  } state_e;

  function automatic logic [31:0] idle_sel(input req_t r, input logic [IDX_W-1:0] idx);
    logic [31:0] v;
    v = '0;
    unique case (idx)
      3'd0:    v = r.idle_cycles_t0;
      3'd1:    v = r.idle_cycles_t1;
      3'd2:    v = r.idle_cycles_t2;
      3'd3:    v = r.idle_cycles_t3;
      3'd4:    v = r.idle_cycles_t4;
      3'd5:    v = r.idle_cycles_t5;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/tilm_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tilm_req_if: request channel
// Valid/ready channel carrying one start or sample request per beat.
// ----------------------------------------------------------------------------
interface tilm_req_if;
  import tilm_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/tilm_res_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tilm_res_if: result channel
// Valid/ready channel carrying one per-thread load result per beat.
// ----------------------------------------------------------------------------
interface tilm_res_if;
  import tilm_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/tilm_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tilm_div: busy percentage divider
// Restoring division, one quotient bit per cycle, seven bits. Flags a
// quotient of 128 or more (or a zero divisor) as over before it starts.
// ----------------------------------------------------------------------------
module tilm_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tilm_pkg::div_req_t req_i,
  output tilm_pkg::div_res_t      res_o
);
  import tilm_pkg::*;

  localparam int unsigned TRIAL_W = DIVR_W + PCT_W;

  logic                 busy_q;
  logic                 done_q;
  logic                 over_q;
  logic [2:0]           step_q;
  logic [DVD_W-1:0]     rem_q;
  logic [DIVR_W-1:0]    divisor_q;
  logic [PCT_W-1:0]     quot_q;
  logic [TRIAL_W-1:0]   trial;
  logic                 fits;
  logic                 over_chk;

  assign trial = TRIAL_W'(divisor_q) << step_q;
  assign fits  = TRIAL_W'(rem_q) >= trial;

  // quotient cannot fit seven bits when dividend >= divisor * 128
  assign over_chk = (req_i.divisor == '0) ||
                    (TRIAL_W'(req_i.dividend) >= {req_i.divisor, {PCT_W{1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= !over_chk;
        done_q <= over_chk;
      end else if (busy_q && (step_q == 3'd0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      divisor_q <= req_i.divisor;
      rem_q     <= req_i.dividend;
      step_q    <= 3'(PCT_W - 1);
      quot_q    <= '0;
      over_q    <= over_chk;
    end else if (busy_q) begin
      if (fits) begin
        rem_q  <= rem_q - trial[DVD_W-1:0];
        quot_q <= quot_q | (PCT_W'(1) << step_q);
      end
      step_q <= step_q - 3'd1;
    end
  end

  assign res_o.done = done_q;
  assign res_o.over = over_q;
  assign res_o.quot = quot_q;

endmodule
`default_nettype wire

/* rtl/thread_idle_load_monitor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// thread_idle_load_monitor: per-thread idle load from cycle counter samples
// Computes idle percentage and busy MIPS per thread from counter deltas.
// ----------------------------------------------------------------------------
// Usage:
//   req_i is a valid/ready request channel. A start beat stores the core,
//   per-thread idle and restart tick readings as the baseline. A sample beat
//   forms wrapping deltas against that baseline, emits one result beat per
//   thread on res_o (thread 0 first, last_result on the final one) and then
//   stores the new baseline. cfg_we_i/cfg_data_i write monitor_enable; while
//   it is 0 request beats are taken and dropped.
//   Sequence: a start beat writes the six baseline entries into the idle
//   count memory, one per cycle. A sample beat runs the setup states PREP
//   and MULT, then per thread a read of the single-port memory (RD), DIFF,
//   SCALE, the seven-step percentage divider (DIVS, DIVW), PCT, MIPS and
//   OUT, and then the six baseline writes.
//   One request is handled at a time; req_i.ready is high only when idle.
//   Results pass through an output register: a stalled receiver holds the
//   per-thread loop, and a new request is taken while the final result
//   still waits. Reset clears the baseline and disables the monitor.
// ----------------------------------------------------------------------------
module thread_idle_load_monitor #(
  parameter int unsigned THREADS = 6
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_data_i,
  tilm_req_if.sink    req_i,
  tilm_res_if.source  res_o
);
  import tilm_pkg::*;

  localparam int unsigned NACT = (THREADS > IDLE_INPUTS) ? IDLE_INPUTS : THREADS;
  localparam logic [IDX_W-1:0] LAST_THR = IDX_W'(NACT - 1);
  localparam logic [IDX_W-1:0] LAST_ENT = IDX_W'(IDLE_INPUTS - 1);

  state_e state_q, state_d;

  logic                   mon_en_q;
  logic [IDX_W-1:0]       thr_q;
  req_t                   req_q;
  logic [31:0]            prev_core_q;
  logic [31:0]            start_tick_q;
  logic [31:0]            net_core_q;
  logic [31:0]            ticks_q;
  logic [DIVR_W-1:0]      divisor_q;
  logic [63:0]            kprod_q;
  logic [DVD_W-1:0]       dvd_q;
  logic [PCT_W-1:0]       idle_q;
  logic [MPROD_W-1:0]     mprod_q;
  logic                   out_valid_q;
  res_t                   out_q;

  // idle count baseline memory
  logic [31:0]            mem [IDLE_INPUTS];
  logic [IDLE_INPUTS-1:0] ent_valid_q;
  logic [31:0]            rdata_q;

  logic                   in_ready;
  logic                   rd_en;
  logic                   mem_we;
  logic                   div_start;
  logic                   out_load;
  logic                   in_acc;

  div_req_t               div_req;
  div_res_t               div_res;

  logic [31:0]            prev_idle;
  logic [31:0]            net_idle;
  logic [31:0]            busy_diff;
  logic [BUSYK_W-1:0]     busy_k;
  logic [PCT_W-1:0]       idle_pct;
  logic [46:0]            mips_prod;

  assign in_acc = req_i.valid && in_ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && mon_en_q) begin
          state_d = (req_i.data.req_type == REQ_SAMPLE) ? ST_PREP : ST_BASE;
        end
      end
      ST_PREP:  state_d = ST_MULT;
      ST_MULT:  state_d = ST_RD;
      ST_RD:    state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_DIVS;
      ST_DIVS:  state_d = ST_DIVW;
      ST_DIVW: begin
        if (div_res.done) begin
          state_d = ST_PCT;
        end
      end
      ST_PCT:   state_d = ST_MIPS;
      ST_MIPS:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = (thr_q == LAST_THR) ? ST_BASE : ST_RD;
        end
      end
      ST_BASE: begin
        if (thr_q == LAST_ENT) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready  = 1'b1;
      ST_RD:    rd_en     = 1'b1;
      ST_DIVS:  div_start = 1'b1;
      ST_OUT:   out_load  = !out_valid_q || res_o.ready;
      ST_BASE:  mem_we    = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mon_en_q     <= 1'b0;
      thr_q        <= '0;
      prev_core_q  <= '0;
      start_tick_q <= '0;
      ent_valid_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mon_en_q <= cfg_data_i;
      end
      if (state_q == ST_IDLE) begin
        thr_q <= '0;
      end else if ((state_q == ST_OUT) && out_load) begin
        thr_q <= (thr_q == LAST_THR) ? '0 : thr_q + IDX_W'(1);
      end else if (state_q == ST_BASE) begin
        thr_q <= thr_q + IDX_W'(1);
      end
      if (mem_we) begin
        ent_valid_q[thr_q] <= 1'b1;
      end
      if (mem_we && (thr_q == LAST_ENT)) begin
        prev_core_q  <= req_q.core_cycles;
        start_tick_q <= req_q.tick_restart;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[thr_q] <= idle_sel(req_q, thr_q);
    end
    if (rd_en) begin
      rdata_q <= mem[thr_q];
    end
  end

  // per-thread datapath
  assign prev_idle = ent_valid_q[thr_q] ? rdata_q : '0;
  assign net_idle  = idle_sel(req_q, thr_q) - prev_idle;
  assign busy_diff = (net_core_q > net_idle) ? (net_core_q - net_idle) : '0;
  assign busy_k    = kprod_q[63:KILO_SHIFT];
  assign idle_pct  = (div_res.over || (div_res.quot > HUNDRED)) ? '0
                                                                : HUNDRED - div_res.quot;
  assign mips_prod = 47'(mprod_q) * 47'(HUNDRED_RECIP);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= req_i.data;
    end
    if (state_q == ST_PREP) begin
      net_core_q <= req_q.core_cycles - prev_core_q;
      ticks_q    <= req_q.tick_end - start_tick_q;
    end
    if (state_q == ST_MULT) begin
      divisor_q <= DIVR_W'(req_q.cpu_mips) * DIVR_W'(ticks_q);
    end
    if (state_q == ST_DIFF) begin
      kprod_q <= 64'(busy_diff) * 64'(KILO_RECIP);
    end
    if (state_q == ST_SCALE) begin
      dvd_q <= DVD_W'(busy_k) * DVD_W'(PCT_SCALE);
    end
    if (state_q == ST_PCT) begin
      idle_q  <= idle_pct;
      mprod_q <= MPROD_W'(HUNDRED - idle_pct) * MPROD_W'(req_q.cpu_mips);
    end
    if (out_load) begin
      out_q.thread_index <= thr_q;
      out_q.idle_percent <= idle_q;
      out_q.busy_mips    <= mips_prod[HUNDRED_SHIFT+15:HUNDRED_SHIFT];
      out_q.last_result  <= (thr_q == LAST_THR);
    end
  end

  assign div_req.start    = div_start;
  assign div_req.dividend = dvd_q;
  assign div_req.divisor  = divisor_q;

  tilm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  assign req_i.ready = in_ready;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

endmodule
`default_nettype wire
